>>> hdl/bbc_pkg.sv
// Package for the bounding box centering block.
// Holds the configuration register codes, fixed widths and shared types.
// No dependencies.
package bbc_pkg;

    // Configuration registers are 15-bit unsigned spans.
    localparam int REG_WIDTH       = 15;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_index;

    localparam logic [REG_WIDTH-1:0] FRAME_WIDTH_RESET  = 15'd1024;
    localparam logic [REG_WIDTH-1:0] FRAME_HEIGHT_RESET = 15'd768;

    // Operation codes carried by each input point.
    typedef enum logic {
        OP_MEASURE = 1'b0,
        OP_SHIFT   = 1'b1
    } t_op;

    // Bounds update request from the stage register to the bounds tracker.
    typedef struct packed {
        logic measure;
        logic first;
    } t_bnd_upd;

endpackage

>>> hdl/bbc_if.sv
// Channel interfaces for the bounding box centering block: points in,
// centered points out and configuration writes. Depends on bbc_pkg.
interface bbc_pt_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic                          first;
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;

    modport source (output valid, output operation, output first, output x_in,
                    output y_in, input ready);
    modport sink   (input valid, input operation, input first, input x_in,
                    input y_in, output ready);
endinterface

interface bbc_res_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;

    modport source (output valid, output x_out, output y_out, input ready);
    modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

interface bbc_cfg_if import bbc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [REG_WIDTH-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/bbc_bounds.sv
// Running min/max tracker for x and y.
// Depends on bbc_pkg for the update request type.
module bbc_bounds import bbc_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_bnd_upd                      i_upd,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    output logic signed [COORD_WIDTH-1:0] o_max_x,
    output logic signed [COORD_WIDTH-1:0] o_min_x,
    output logic signed [COORD_WIDTH-1:0] o_max_y,
    output logic signed [COORD_WIDTH-1:0] o_min_y
);

    logic signed [COORD_WIDTH-1:0] r_max_x, r_min_x, r_max_y, r_min_y;
    logic signed [COORD_WIDTH-1:0] n_max_x, n_min_x, n_max_y, n_min_y;

    always_comb begin
        n_max_x = r_max_x;
        n_min_x = r_min_x;
        n_max_y = r_max_y;
        n_min_y = r_min_y;
        if (i_upd.measure) begin
            if (i_upd.first) begin
                // restart bounds from this point
                n_max_x = i_x;
                n_min_x = i_x;
                n_max_y = i_y;
                n_min_y = i_y;
            end else begin
                if (i_x > r_max_x) n_max_x = i_x;
                if (i_x < r_min_x) n_min_x = i_x;
                if (i_y > r_max_y) n_max_y = i_y;
                if (i_y < r_min_y) n_min_y = i_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= '0;
            r_min_x <= '0;
            r_max_y <= '0;
            r_min_y <= '0;
        end else begin
            r_max_x <= n_max_x;
            r_min_x <= n_min_x;
            r_max_y <= n_max_y;
            r_min_y <= n_min_y;
        end
    end

    assign o_max_x = r_max_x;
    assign o_min_x = r_min_x;
    assign o_max_y = r_max_y;
    assign o_min_y = r_min_y;

endmodule

>>> hdl/bbc_center.sv
// One axis of the centering datapath: offset = (span - max - min) / 2,
// truncated toward zero, added to the point and saturated. Depends on bbc_pkg.
module bbc_center import bbc_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic signed [COORD_WIDTH-1:0] i_p,
    input  logic        [REG_WIDTH-1:0]   i_span,
    input  logic signed [COORD_WIDTH-1:0] i_hi,
    input  logic signed [COORD_WIDTH-1:0] i_lo,
    output logic signed [COORD_WIDTH-1:0] o_q
);

    localparam int BASE_W = (COORD_WIDTH > REG_WIDTH) ? COORD_WIDTH : REG_WIDTH;
    localparam int SUM_W  = BASE_W + 2;

    localparam logic signed [SUM_W:0] SAT_HI =
        {{(SUM_W-COORD_WIDTH+2){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W:0] SAT_LO =
        {{(SUM_W-COORD_WIDTH+2){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] rnd;
    logic signed [SUM_W-1:0] offset;
    logic signed [SUM_W:0]   moved;

    always_comb begin
        diff   = SUM_W'(signed'({1'b0, i_span})) - SUM_W'(i_hi) - SUM_W'(i_lo);
        // add one before the shift on negative values to round toward zero
        rnd    = diff + signed'({{(SUM_W-1){1'b0}}, diff[SUM_W-1]});
        offset = rnd >>> 1;
        moved  = (SUM_W+1)'(i_p) + (SUM_W+1)'(offset);
        if (moved > SAT_HI) begin
            o_q = SAT_HI[COORD_WIDTH-1:0];
        end else if (moved < SAT_LO) begin
            o_q = SAT_LO[COORD_WIDTH-1:0];
        end else begin
            o_q = moved[COORD_WIDTH-1:0];
        end
    end

endmodule

>>> hdl/bounding_box_centering.sv
// Bounding box centering of a point stream. Measure points (operation 0)
// grow the running x/y bounds, or restart them when first is set, and give
// no result. Shift points (operation 1) come back moved by
// (span - max - min) / 2 per axis, truncated toward zero and saturated to
// COORD_WIDTH bits, x centered on frame_width and y on frame_height. The
// block takes one point per cycle unless the stage stalls: a point lands in
// a stage register, where a measure updates the bounds and a shift is
// centered against the bounds left by the earlier measure points; the
// centered result is then held in an output register until the sink takes
// it, so a shift result passes the stage register and then the output
// register. The stage register and the output register together set the
// one-point-per-cycle rate; the stage stalls only when a shift result finds
// the output register full and not being drained. Configuration writes are
// taken in any cycle; index 0 is frame_width, index 1 frame_height, other
// indexes are dropped. Write them only while no point is in flight.
module bounding_box_centering import bbc_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_pt_if.sink    i_pt,
    bbc_res_if.source o_res,
    bbc_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [REG_WIDTH-1:0] r_frame_width;
    logic [REG_WIDTH-1:0] r_frame_height;

    // stage register
    logic                          r_stg_valid;
    t_op                           r_stg_op;
    logic                          r_stg_first;
    logic signed [COORD_WIDTH-1:0] r_stg_x;
    logic signed [COORD_WIDTH-1:0] r_stg_y;

    // output register
    logic                          r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_out_x;
    logic signed [COORD_WIDTH-1:0] r_out_y;

    logic     out_free;
    logic     stg_adv;
    logic     load_out;
    t_bnd_upd bnd_upd;

    logic signed [COORD_WIDTH-1:0] max_x, min_x, max_y, min_y;
    logic signed [COORD_WIDTH-1:0] cx, cy;

    // Handshake: a measure always leaves the stage, a shift leaves only
    // when the output register is empty or being drained.
    assign out_free   = !r_out_valid || o_res.ready;
    assign stg_adv    = r_stg_valid && ((r_stg_op == OP_MEASURE) || out_free);
    assign load_out   = r_stg_valid && (r_stg_op == OP_SHIFT) && out_free;
    assign i_pt.ready = !r_stg_valid || stg_adv;
    assign i_cfg.ready = 1'b1;

    // Advance the bounds with the measure point sitting in the stage.
    assign bnd_upd.measure = r_stg_valid && (r_stg_op == OP_MEASURE);
    assign bnd_upd.first   = r_stg_first;

    bbc_bounds #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_bounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (bnd_upd),
        .i_x     (r_stg_x),
        .i_y     (r_stg_y),
        .o_max_x (max_x),
        .o_min_x (min_x),
        .o_max_y (max_y),
        .o_min_y (min_y)
    );

    bbc_center #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_center_x (
        .i_p    (r_stg_x),
        .i_span (r_frame_width),
        .i_hi   (max_x),
        .i_lo   (min_x),
        .o_q    (cx)
    );

    bbc_center #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_center_y (
        .i_p    (r_stg_y),
        .i_span (r_frame_height),
        .i_hi   (max_y),
        .i_lo   (min_y),
        .o_q    (cy)
    );

    // Configuration writes: drop indexes beyond the register list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage register: take a new transaction whenever the stage frees up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (i_pt.ready) begin
            r_stg_valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt.valid && i_pt.ready) begin
            r_stg_op    <= t_op'(i_pt.operation);
            r_stg_first <= i_pt.first;
            r_stg_x     <= i_pt.x_in;
            r_stg_y     <= i_pt.y_in;
        end
    end

    // Output register: hold the result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x <= cx;
            r_out_y <= cy;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.x_out = r_out_x;
    assign o_res.y_out = r_out_y;

    // A new result only ever comes from a shift point leaving the stage.
    a_out_from_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |->
            $past(r_stg_valid && (r_stg_op == OP_SHIFT)))
        else $error("result appeared without a shift point");

    // A stalled stage keeps its point.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stg_valid && !stg_adv) |=>
            (r_stg_valid && $stable(r_stg_x) && $stable(r_stg_y)
             && $stable(r_stg_op)))
        else $error("stalled stage lost its point");

    // A shift point never waits while the output register is empty.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stg_valid && (r_stg_op == OP_SHIFT) && !r_out_valid) |=>
            r_out_valid)
        else $error("shift point stalled with an empty output register");

    // Bounds stay ordered on both axes.
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (max_x >= min_x) && (max_y >= min_y))
        else $error("bounds out of order");

endmodule
